// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");

`endif

// ----- rtl/rmmp_pkg.sv -----
package rmmp_pkg;

	localparam int TOK_DEPTH = 8;
	localparam int IDX_W     = $clog2(TOK_DEPTH);
	localparam int CNT_W     = IDX_W + 1;

	localparam logic [7:0] CH_BTICK = 8'h60;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_BANG  = 8'h21;

	localparam logic [15:0] DEFAULT_COLOUR_RST = 16'hFFFF;
	localparam logic        ADDR_DEFAULT_COLOUR = 1'b0;

	// flag bit positions
	localparam int FL_UNDER  = 0;
	localparam int FL_LINE   = 1;
	localparam int FL_ALWAYS = 2;
	localparam int FL_NEVER  = 3;
	localparam int FL_COLOUR = 4;

	// m_tdata layout
	localparam int OD_ROW    = 0;
	localparam int OD_BYTE   = 8;
	localparam int OD_COLOUR = 16;
	localparam int OD_GIVEN  = 32;
	localparam int OD_UNDER  = 33;
	localparam int OD_LINE   = 34;
	localparam int OD_ALWAYS = 35;
	localparam int OD_NEVER  = 36;
	localparam int OD_W      = 40;

	typedef enum logic [1:0] {
		PH_PREFIX,
		PH_TOKEN,
		PH_BODY
	} phase_t;

	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] cnt;
		logic [4:0]       flags;
	} rmmp_state_t;

	typedef struct packed {
		logic             attr;
		logic             attr_last;
		logic [CNT_W-1:0] flush_n;
		logic             trail;
		logic             eor;
		logic [4:0]       flags;
	} rmmp_plan_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] widx;
		logic             hex_sh;
		logic [3:0]       nib;
		logic             colour_ld;
	} rmmp_ctl_t;

	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
			r = {1'b1, 4'(b[3:0] + 4'd9)};
		end
		return r;
	endfunction

	function automatic logic is_modifier(input logic [7:0] b);
		return (b == CH_UNDER) || (b == CH_DASH) || (b == CH_TILDE) || (b == CH_BANG);
	endfunction

	function automatic logic [4:0] modifier_mask(input logic [7:0] b);
		logic [4:0] m;
		m = 5'd0;
		if (b == CH_UNDER) m[FL_UNDER] = 1'b1;
		else if (b == CH_DASH) m[FL_LINE] = 1'b1;
		else if (b == CH_TILDE) m[FL_ALWAYS] = 1'b1;
		else if (b == CH_BANG) m[FL_NEVER] = 1'b1;
		return m;
	endfunction

endpackage

// ----- rtl/rmmp_step.sv -----
module rmmp_step import rmmp_pkg::*; (
	input  rmmp_state_t st,
	input  logic [7:0]  text_byte,
	input  logic        end_of_row,
	input  logic [7:0]  tok1,
	output rmmp_state_t nx,
	output rmmp_plan_t  plan,
	output rmmp_ctl_t   ctl
);

	logic [4:0] hex;
	logic [4:0] fl;
	logic       end_p;
	logic       fail;
	logic       trail;
	logic [CNT_W-1:0] flush_n;

	assign hex = hex_digit(text_byte);

	always_comb begin
		nx      = st;
		fl      = st.flags;
		end_p   = 1'b0;
		fail    = 1'b0;
		trail   = 1'b0;
		flush_n = '0;
		ctl     = '0;
		ctl.nib = hex[3:0];

		case (st.phase)
			PH_PREFIX: begin
				if (text_byte == CH_BTICK) begin
					ctl.we   = 1'b1;
					ctl.widx = '0;
					nx.cnt   = CNT_W'(1);
					nx.phase = PH_TOKEN;
				end else begin
					end_p = 1'b1;
					trail = 1'b1;
				end
			end
			PH_TOKEN: begin
				if (st.cnt == CNT_W'(1)) begin
					if (is_modifier(text_byte) || text_byte == CH_HASH) begin
						ctl.we   = 1'b1;
						ctl.widx = IDX_W'(1);
						nx.cnt   = CNT_W'(2);
					end else begin
						fail = 1'b1;
					end
				end else if (st.cnt == CNT_W'(2) && is_modifier(tok1)) begin
					if (text_byte == CH_BTICK) begin
						fl       = fl | modifier_mask(tok1);
						nx.cnt   = '0;
						nx.phase = PH_PREFIX;
					end else begin
						fail = 1'b1;
					end
				end else if (st.cnt >= CNT_W'(2) && st.cnt < CNT_W'(TOK_DEPTH)
						&& tok1 == CH_HASH) begin
					if (hex[4]) begin
						ctl.we     = 1'b1;
						ctl.widx   = st.cnt[IDX_W-1:0];
						ctl.hex_sh = 1'b1;
						nx.cnt     = CNT_W'(st.cnt + CNT_W'(1));
					end else begin
						fail = 1'b1;
					end
				end else if (st.cnt == CNT_W'(TOK_DEPTH) && tok1 == CH_HASH
						&& text_byte == CH_BTICK) begin
					ctl.colour_ld = 1'b1;
					fl[FL_COLOUR] = 1'b1;
					nx.cnt        = '0;
					end_p         = 1'b1;
				end else begin
					fail = 1'b1;
				end
				if (fail) begin
					end_p   = 1'b1;
					flush_n = st.cnt;
					nx.cnt  = '0;
					trail   = 1'b1;
				end
			end
			default: begin
				trail = 1'b1;
			end
		endcase

		if (end_p) begin
			nx.phase = PH_BODY;
		end
		// row ends inside the prefix: close it and drain the open token
		if (end_of_row && nx.phase != PH_BODY) begin
			end_p    = 1'b1;
			flush_n  = nx.cnt;
			nx.cnt   = '0;
			nx.phase = PH_BODY;
		end

		if (end_p) begin
			if (fl[FL_LINE]) begin
				fl[FL_UNDER]  = 1'b0;
				fl[FL_ALWAYS] = 1'b0;
				fl[FL_NEVER]  = 1'b0;
			end
			if (fl[FL_ALWAYS] && fl[FL_NEVER]) begin
				fl[FL_ALWAYS] = 1'b0;
				fl[FL_NEVER]  = 1'b0;
			end
		end

		if (fl[FL_LINE]) begin
			flush_n = '0;
			trail   = 1'b0;
		end

		plan.attr      = end_p;
		plan.attr_last = fl[FL_LINE];
		plan.flush_n   = flush_n;
		plan.trail     = trail;
		plan.eor       = end_of_row;
		plan.flags     = fl;

		nx.flags = fl;
		if (end_of_row) begin
			nx.phase = PH_PREFIX;
			nx.cnt   = '0;
			nx.flags = '0;
		end
	end

endmodule

// ----- rtl/row_markup_modifier_parser.sv -----
// Channel     | Direction | Payload
// s_*         | in        | tdata {text_byte, row_id}, tlast end_of_row
// m_*         | out       | tdata {flags, colour565, out_byte, row_number}, tuser kind,
//             |           | tlast last_of_row
// APB         | in/out    | default_colour at byte address 0
//
// An item producing at most one result is taken every cycle while m_tready is high.
// An item producing n results holds s_tready low while the
// output register walks its plan: attribute, token bytes, then the byte itself;
// the token buffer drains one byte per cycle while m_tready is high.
// Reset restores the prefix state and default_colour 0xFFFF; no clearing pass.
// A stall on m_tready holds the current result and blocks new requests.
module row_markup_modifier_parser import rmmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // row_id, text_byte
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	// row_number, out_byte, colour565, colour_given, underline, line_only,
	// ticker_always, ticker_never, zero pad
	output logic [OD_W-1:0]   m_tdata,
	output logic              m_tuser,   // kind
	output logic              m_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	rmmp_state_t st_q;
	rmmp_state_t st_nx;
	rmmp_plan_t  plan;
	rmmp_ctl_t   ctl;

	logic [15:0] dcol_q;
	logic [15:0] colour_q;
	logic [23:0] rgb_q;
	logic [7:0]  tok_q [TOK_DEPTH];

	logic             attr_s1;
	logic             attr_last_s1;
	logic [CNT_W-1:0] flush_s1;
	logic             trail_s1;
	logic             eor_s1;
	logic [4:0]       flags_s1;
	logic [15:0]      colour_s1;
	logic [7:0]       row_s1;
	logic [7:0]       byte_s1;

	logic        accept;
	logic        advance;
	logic        final_item;
	logic        shift;
	logic [15:0] colour_new;
	logic [15:0] colour_sel;
	logic [7:0]  out_byte;

	rmmp_step u_step (
		.st         (st_q),
		.text_byte  (s_tdata[15:8]),
		.end_of_row (s_tlast),
		.tok1       (tok_q[1]),
		.nx         (st_nx),
		.plan       (plan),
		.ctl        (ctl)
	);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_DEFAULT_COLOUR) ? {16'd0, dcol_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcol_q <= DEFAULT_COLOUR_RST;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == ADDR_DEFAULT_COLOUR) begin
			dcol_q <= pwdata[15:0];
		end
	end

	assign colour_new = {rgb_q[23:19], rgb_q[15:10], rgb_q[7:3]};
	assign colour_sel = !plan.flags[FL_COLOUR] ? dcol_q :
		(ctl.colour_ld ? colour_new : colour_q);

	assign m_tvalid = attr_s1 || (flush_s1 != '0) || trail_s1;
	assign final_item = attr_s1 ? (flush_s1 == '0 && !trail_s1) :
		((flush_s1 != '0) ? (flush_s1 == CNT_W'(1) && !trail_s1) : 1'b1);
	assign advance  = m_tvalid && m_tready;
	assign s_tready = !m_tvalid || (m_tready && final_item);
	assign accept   = s_tvalid && s_tready;
	assign shift    = advance && !attr_s1 && (flush_s1 != '0);

	assign out_byte = attr_s1 ? 8'd0 : ((flush_s1 != '0) ? tok_q[0] : byte_s1);

	assign m_tuser = attr_s1;
	assign m_tlast = (attr_s1 && attr_last_s1) || (eor_s1 && final_item);
	assign m_tdata = {3'd0, flags_s1[FL_NEVER], flags_s1[FL_ALWAYS], flags_s1[FL_LINE],
		flags_s1[FL_UNDER], flags_s1[FL_COLOUR], colour_s1, out_byte, row_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '{phase: PH_PREFIX, cnt: '0, flags: '0};
			attr_s1  <= 1'b0;
			flush_s1 <= '0;
			trail_s1 <= 1'b0;
		end else if (accept) begin
			st_q     <= st_nx;
			attr_s1  <= plan.attr;
			flush_s1 <= plan.flush_n;
			trail_s1 <= plan.trail;
		end else if (advance) begin
			if (attr_s1) begin
				attr_s1 <= 1'b0;
			end else if (flush_s1 != '0) begin
				flush_s1 <= CNT_W'(flush_s1 - CNT_W'(1));
			end else begin
				trail_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			attr_last_s1 <= plan.attr_last;
			eor_s1       <= plan.eor;
			flags_s1     <= plan.flags;
			colour_s1    <= colour_sel;
			row_s1       <= s_tdata[7:0];
			byte_s1      <= s_tdata[15:8];
			if (ctl.hex_sh) begin
				rgb_q <= {rgb_q[19:0], ctl.nib};
			end
			if (ctl.colour_ld) begin
				colour_q <= colour_new;
			end
		end
	end

	// drain toward entry 0; a new write wins over the shift
	always_ff @(posedge clk) begin
		if (shift) begin
			for (int i = 0; i < TOK_DEPTH - 1; i++) begin
				tok_q[i] <= tok_q[i+1];
			end
		end
		if (accept && ctl.we) begin
			tok_q[ctl.widx] <= s_tdata[15:8];
		end
	end

endmodule

// ----- rtl/rmmp_checker.sv -----
`include "assert_macros.svh"

module rmmp_checker import rmmp_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            m_tvalid,
	input logic            m_tready,
	input logic [OD_W-1:0] m_tdata,
	input logic            m_tuser,
	input logic            m_tlast
);

	// hold a stalled result
	`ASSERT_CLK(a_stall_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
	// a line row closes on its attribute
	`ASSERT_CLK(a_line_attr_last, clk, arst_n, m_tvalid && m_tuser && m_tdata[OD_LINE] |-> m_tlast)
	// drop all text of a line row
	`ASSERT_NEVER(a_line_no_text, clk, arst_n, m_tvalid && !m_tuser && m_tdata[OD_LINE])
	// sanitized tickers are exclusive
	`ASSERT_NEVER(a_ticker_excl, clk, arst_n, m_tvalid && m_tdata[OD_ALWAYS] && m_tdata[OD_NEVER])
	// a line row carries no other attribute flag
	`ASSERT_NEVER(a_line_clean, clk, arst_n, m_tvalid && m_tdata[OD_LINE] && (m_tdata[OD_UNDER] || m_tdata[OD_ALWAYS] || m_tdata[OD_NEVER]))

endmodule

bind row_markup_modifier_parser rmmp_checker u_rmmp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ----- verif/row_markup_modifier_parser_tb.sv -----
module row_markup_modifier_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rmmp_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_CHARS = 60;

	typedef struct packed {
		logic [7:0] row_id;
		logic [7:0] text_byte;
		logic       end_of_row;
	} char_req_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  row_number;
		logic [7:0]  out_byte;
		logic [15:0] colour565;
		logic        colour_given;
		logic        underline;
		logic        line_only;
		logic        ticker_always;
		logic        ticker_never;
		logic        last_of_row;
	} row_item_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [15:0]       s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OD_W-1:0]   m_tdata;
	logic              m_tuser;
	logic              m_tlast;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	row_markup_modifier_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	char_req_t  chars_to_send[$];
	row_item_t  row_items_due[$];
	logic [7:0] row_text[$];
	int         sent_cnt = 0;
	int         taken_cnt = 0;
	int         errs = 0;
	int         quiet = 0;
	int         gap_left = 0;
	int         stall_left = 0;
	int         chars_queued = 0;
	logic       calm = 1'b0;

	// parser state mirror
	phase_t      row_phase = PH_PREFIX;
	logic [7:0]  tok_buf[8];
	int          tok_cnt = 0;
	logic [4:0]  flags = '0;
	logic [15:0] colour_val = DEFAULT_COLOUR_RST;
	logic [15:0] dflt_colour = DEFAULT_COLOUR_RST;

	wire s_fire = s_tvalid && s_tready;
	wire m_fire = m_tvalid && m_tready;

	function automatic logic [4:0] hex_val(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) return 5'(b - 8'h30);
		if (b >= 8'h41 && b <= 8'h46) return 5'(b - 8'h37);
		if (b >= 8'h61 && b <= 8'h66) return 5'(b - 8'h57);
		return 5'd16;
	endfunction

	function automatic void emit_item(input logic kind, input logic [7:0] row,
			input logic [7:0] b, input logic last);
		row_item_t r;
		r.kind = kind;
		r.row_number = row;
		r.out_byte = b;
		r.colour565 = flags[FL_COLOUR] ? colour_val : dflt_colour;
		r.colour_given = flags[FL_COLOUR];
		r.underline = flags[FL_UNDER];
		r.line_only = flags[FL_LINE];
		r.ticker_always = flags[FL_ALWAYS];
		r.ticker_never = flags[FL_NEVER];
		r.last_of_row = last;
		row_items_due.push_back(r);
	endfunction

	function automatic void put_char(input logic [7:0] row, input logic [7:0] b);
		if (!flags[FL_LINE]) emit_item(1'b0, row, b, 1'b0);
	endfunction

	function automatic void close_prefix(input logic [7:0] row);
		if (flags[FL_LINE]) begin
			flags[FL_UNDER] = 1'b0;
			flags[FL_ALWAYS] = 1'b0;
			flags[FL_NEVER] = 1'b0;
		end
		if (flags[FL_ALWAYS] && flags[FL_NEVER]) begin
			flags[FL_ALWAYS] = 1'b0;
			flags[FL_NEVER] = 1'b0;
		end
		emit_item(1'b1, row, 8'h00, flags[FL_LINE]);
		row_phase = PH_BODY;
	endfunction

	function automatic void flush_buf(input logic [7:0] row);
		for (int i = 0; i < tok_cnt; i++) put_char(row, tok_buf[i]);
		tok_cnt = 0;
	endfunction

	function automatic void parse_char(input logic [7:0] row, input logic [7:0] b,
			input logic eor);
		int         base_cnt;
		int         c;
		logic       fail;
		logic       is_mod;
		logic [4:0] nib;
		logic [23:0] rgb;
		row_item_t  r;
		base_cnt = row_items_due.size();
		c = tok_cnt;
		fail = 1'b0;
		is_mod = (tok_buf[1] == CH_UNDER) || (tok_buf[1] == CH_DASH) ||
			(tok_buf[1] == CH_TILDE) || (tok_buf[1] == CH_BANG);
		case (row_phase)
			PH_PREFIX: begin
				if (b == CH_BTICK) begin
					tok_buf[0] = b;
					tok_cnt = 1;
					row_phase = PH_TOKEN;
				end else begin
					close_prefix(row);
					put_char(row, b);
				end
			end
			PH_TOKEN: begin
				if (c == 1) begin
					if (b == CH_UNDER || b == CH_DASH || b == CH_TILDE || b == CH_BANG ||
							b == CH_HASH) begin
						tok_buf[1] = b;
						tok_cnt = 2;
					end else begin
						fail = 1'b1;
					end
				end else if (c == 2 && is_mod) begin
					if (b == CH_BTICK) begin
						case (tok_buf[1])
							CH_UNDER: flags[FL_UNDER] = 1'b1;
							CH_DASH:  flags[FL_LINE] = 1'b1;
							CH_TILDE: flags[FL_ALWAYS] = 1'b1;
							default:  flags[FL_NEVER] = 1'b1;
						endcase
						tok_cnt = 0;
						row_phase = PH_PREFIX;
					end else begin
						fail = 1'b1;
					end
				end else if (c >= 2 && c < 8 && tok_buf[1] == CH_HASH) begin
					if (hex_val(b) < 5'd16) begin
						tok_buf[c] = b;
						tok_cnt = c + 1;
					end else begin
						fail = 1'b1;
					end
				end else if (c == 8 && tok_buf[1] == CH_HASH && b == CH_BTICK) begin
					rgb = '0;
					for (int i = 2; i < 8; i++) begin
						nib = hex_val(tok_buf[i]);
						rgb = {rgb[19:0], nib[3:0]};
					end
					colour_val = {rgb[23:19], rgb[15:10], rgb[7:3]};
					flags[FL_COLOUR] = 1'b1;
					tok_cnt = 0;
					close_prefix(row);
				end else begin
					fail = 1'b1;
				end
				if (fail) begin
					close_prefix(row);
					flush_buf(row);
					put_char(row, b);
				end
			end
			default: put_char(row, b);
		endcase
		if (eor) begin
			if (row_phase != PH_BODY) begin
				close_prefix(row);
				flush_buf(row);
			end
			if (row_items_due.size() > base_cnt && !flags[FL_LINE]) begin
				r = row_items_due.pop_back();
				r.last_of_row = 1'b1;
				row_items_due.push_back(r);
			end
			row_phase = PH_PREFIX;
			tok_cnt = 0;
			flags = '0;
			colour_val = dflt_colour;
		end
	endfunction

	task automatic cmp_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errs++;
		end
	endtask

	always @(negedge clk) begin : drive_requests
		char_req_t req;
		if (arst_n && !(s_tvalid && taken_cnt != sent_cnt)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (chars_to_send.size() > 0) begin
				req = chars_to_send.pop_front();
				s_tdata <= {req.text_byte, req.row_id};
				s_tlast <= req.end_of_row;
				s_tvalid <= 1'b1;
				sent_cnt <= sent_cnt + 1;
				if (!calm && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(1, 13);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				stall_left <= $urandom_range(0, 12);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watch_results
		row_item_t want;
		if (arst_n) begin
			if (s_fire) begin
				parse_char(s_tdata[7:0], s_tdata[15:8], s_tlast);
				taken_cnt <= taken_cnt + 1;
			end
			if (m_fire) begin
				if (row_items_due.size() == 0) begin
					$error("unexpected result: row %0h byte %0h kind %0b",
						m_tdata[OD_ROW +: 8], m_tdata[OD_BYTE +: 8], m_tuser);
					errs++;
				end else begin
					want = row_items_due.pop_front();
					cmp_field("kind", want.kind, m_tuser);
					cmp_field("row_number", want.row_number, m_tdata[OD_ROW +: 8]);
					cmp_field("out_byte", want.out_byte, m_tdata[OD_BYTE +: 8]);
					cmp_field("colour565", want.colour565, m_tdata[OD_COLOUR +: 16]);
					cmp_field("colour_given", want.colour_given, m_tdata[OD_GIVEN]);
					cmp_field("underline", want.underline, m_tdata[OD_UNDER]);
					cmp_field("line_only", want.line_only, m_tdata[OD_LINE]);
					cmp_field("ticker_always", want.ticker_always, m_tdata[OD_ALWAYS]);
					cmp_field("ticker_never", want.ticker_never, m_tdata[OD_NEVER]);
					cmp_field("last_of_row", want.last_of_row, m_tlast);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_fire || m_fire) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("row_markup_modifier_parser_tb: errors");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	function automatic logic [7:0] pick_mod();
		case ($urandom_range(0, 6))
			0, 1:    return CH_UNDER;
			2, 3:    return CH_TILDE;
			4, 5:    return CH_BANG;
			default: return CH_DASH;
		endcase
	endfunction

	function automatic logic [7:0] pick_hex();
		int v;
		v = $urandom_range(0, 21);
		if (v < 10) return 8'(8'h30 + v);
		if (v < 16) return 8'(8'h41 + v - 10);
		return 8'(8'h61 + v - 16);
	endfunction

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 7))
			0:       return CH_BTICK;
			1:       return CH_HASH;
			2:       return pick_mod();
			3:       return pick_hex();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic put_row(input logic [7:0] row);
		char_req_t req;
		for (int i = 0; i < row_text.size(); i++) begin
			req.row_id = row;
			req.text_byte = row_text[i];
			req.end_of_row = (i == row_text.size() - 1);
			chars_to_send.push_back(req);
			chars_queued++;
		end
		row_text.delete();
	endtask

	task automatic add_random_row();
		int style;
		int n;
		int cut;
		style = $urandom_range(0, 9);
		if (style < 9) begin
			n = $urandom_range(0, 3);
			repeat (n) begin
				row_text.push_back(CH_BTICK);
				row_text.push_back(pick_mod());
				row_text.push_back(CH_BTICK);
			end
			if ($urandom_range(0, 1)) begin
				row_text.push_back(CH_BTICK);
				row_text.push_back(CH_HASH);
				repeat (6) row_text.push_back(pick_hex());
				row_text.push_back(CH_BTICK);
			end
			// break the trailing token
			if (style >= 7 && row_text.size() > 0) begin
				cut = $urandom_range(1, row_text.size() > 8 ? 8 : row_text.size());
				repeat (cut) void'(row_text.pop_back());
				if ($urandom_range(0, 1)) row_text.push_back(pick_char());
			end
			n = $urandom_range(0, 6);
			repeat (n)
				row_text.push_back($urandom_range(0, 3) == 0 ? pick_char() :
					8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(1, 8);
			repeat (n) row_text.push_back(pick_char());
		end
		if (row_text.size() == 0) row_text.push_back(8'($urandom_range(0, 255)));
		put_row(8'($urandom_range(0, 255)));
	endtask

	task automatic wait_idle();
		while (chars_to_send.size() > 0 || taken_cnt != sent_cnt || row_items_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write_colour(input logic [15:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {ADDR_DEFAULT_COLOUR, 2'b00};
		pwdata = {16'h0000, value};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		dflt_colour = value;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		apb_write_colour(16'h0000);

		// both ticker flags set, extreme row and byte
		row_text = '{CH_BTICK, CH_TILDE, CH_BTICK, CH_BTICK, CH_BANG, CH_BTICK, 8'hFF};
		put_row(8'hFF);
		// colour token with mixed-case hex, row ends on the closing backtick
		row_text = '{CH_BTICK, CH_HASH, 8'h61, 8'h46, 8'h39, 8'h42, 8'h30, 8'h65, CH_BTICK};
		put_row(8'h00);
		// line row masks underline and drops its text
		row_text = '{CH_BTICK, CH_DASH, CH_BTICK, CH_BTICK, CH_UNDER, CH_BTICK, 8'h00};
		put_row(8'h5A);
		// row ends inside an unfinished colour token
		row_text = '{CH_BTICK, CH_HASH, 8'h31};
		put_row(8'hA5);

		for (int p = 0; p < 4; p++) begin
			wait_idle();
			case (p)
				0:       apb_write_colour(16'hFFFF);
				2:       apb_write_colour(16'hF800);
				default: apb_write_colour(16'($urandom_range(0, 65535)));
			endcase
			if (p == 3) calm = 1'b1;
			chars_queued = 0;
			while (chars_queued < PHASE_CHARS) add_random_row();
		end

		wait_idle();
		if (errs == 0) begin
			$display("row_markup_modifier_parser_tb: clean");
		end else begin
			$display("row_markup_modifier_parser_tb: errors");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rmmp_pkg.sv
rtl/rmmp_step.sv
rtl/row_markup_modifier_parser.sv
rtl/rmmp_checker.sv
verif/row_markup_modifier_parser_tb.sv
